// ===== rtl/tbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tournament branch predictor package
// Operation codes and saturating counter helpers shared by the predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_UNCOND = 2'd1,
        OP_UPDATE = 2'd2,
        OP_SQUASH = 2'd3
    } op_t;

    // widest counter any table may use
    localparam int CTR_W_MAX = 8;

    typedef logic [CTR_W_MAX-1:0] ctr_t;

    // saturating step toward up or down, clipped at zero and at maxv
    function automatic ctr_t ctr_train(input ctr_t c, input logic up, input ctr_t maxv);
        ctr_t r;
        if (up)
        begin
            r = (c < maxv) ? c + ctr_t'(1) : maxv;
        end
        else
        begin
            r = (c != '0) ? c - ctr_t'(1) : '0;
        end
        return r;
    endfunction

endpackage : tbp_pkg
`default_nettype wire

// ===== rtl/tbp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Predictor table RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module tbp_ram #(
    parameter int W     = 2,
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);

    logic [W-1:0] mem_reg [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : tbp_ram
`default_nettype wire

// ===== rtl/tournament_branch_predictor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: a beat passes the s1, s2 and output registers before its result is valid.
// Throughput: one beat per cycle; stalls come from output back-pressure and the clearing pass.
// Table reads are registered RAM reads; back-to-back hazards resolve by forwarding.
// Reset: global history clears, address_shift returns to 2, then a clearing pass
// over a counter of max(log2(LOCAL_HIST_ENTRIES), LOCAL_HIST_BITS, GLOBAL_HIST_BITS) bits
// (13 at defaults) zeroes all tables with s_tready held low.
// ----------------------------------------------------------------------------
// Tournament branch predictor
// Local / global / choice predictor with speculative global history and squash.
// ----------------------------------------------------------------------------
module tournament_branch_predictor #(
    parameter int LOCAL_HIST_ENTRIES = 2048,
    parameter int LOCAL_HIST_BITS    = 11,
    parameter int GLOBAL_HIST_BITS   = 13,
    parameter int LOCAL_CTR_BITS     = 2,
    parameter int GLOBAL_CTR_BITS    = 2,
    parameter int CHOICE_CTR_BITS    = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_data,  // address_shift
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pc[31:0], taken[32], has_record[33], rec_local_pred[34],
    // rec_global_pred[35], rec_global_history[48:36], zero pad[55:49]
    input  wire logic [55:0] s_tdata,
    input  wire logic [1:0]  s_tuser,      // operation[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // predict_taken[0], local_pred[1], global_pred[2], global_used[3],
    // history_snapshot[16:4], zero pad[23:17]
    output logic [23:0]      m_tdata
);

    import tbp_pkg::*;

    localparam int LHI_W    = $clog2(LOCAL_HIST_ENTRIES);
    localparam int LHB      = LOCAL_HIST_BITS;
    localparam int GHB      = GLOBAL_HIST_BITS;
    localparam int LC_DEPTH = 1 << LOCAL_HIST_BITS;
    localparam int GC_DEPTH = 1 << GLOBAL_HIST_BITS;
    localparam int CLR_W0   = (LHI_W > LHB) ? LHI_W : LHB;
    localparam int CLR_W    = (CLR_W0 > GHB) ? CLR_W0 : GHB;
    localparam int SNAP_W   = 13;
    localparam int HW       = (GHB > SNAP_W) ? GHB : SNAP_W;
    localparam int OUT_W    = 4 + SNAP_W;

    localparam logic [LHI_W-1:0] LH_IDX_MASK = LHI_W'(LOCAL_HIST_ENTRIES - 1);
    localparam ctr_t TAKEN_THR = ctr_t'(((1 << (LOCAL_CTR_BITS - 1)) - 1) / 2);
    localparam ctr_t LC_MAX    = ctr_t'((1 << LOCAL_CTR_BITS) - 1);
    localparam ctr_t GC_MAX    = ctr_t'((1 << GLOBAL_CTR_BITS) - 1);
    localparam ctr_t CC_MAX    = ctr_t'((1 << CHOICE_CTR_BITS) - 1);
    localparam logic [2:0] ADDR_SHIFT_RST = 3'd2;

    // input beat fields
    op_t              in_op;
    logic [31:0]      in_addr;
    logic [31:0]      addr_shifted;
    logic [LHI_W-1:0] in_li;
    logic [HW-1:0]    in_rgh_wide;

    // control
    logic             adv;
    logic             in_fire;
    logic             clr_busy_reg;
    logic [CLR_W-1:0] clr_cnt_reg;
    logic             clr_lh_ok;
    logic [2:0]       addr_shift_reg;
    logic [GHB-1:0]   gh_reg;
    logic [GHB-1:0]   gh_next;
    logic [GHB-1:0]   gh_s1;

    // stage 1
    logic             s1_vld_reg;
    op_t              s1_op_reg;
    logic [LHI_W-1:0] s1_li_reg;
    logic             s1_taken_reg;
    logic             s1_has_rec_reg;
    logic             s1_rlp_reg;
    logic             s1_rgp_reg;
    logic [GHB-1:0]   s1_rgh_reg;
    logic [LHB-1:0]   lh_s1;

    // stage 2
    logic             s2_vld_reg;
    op_t              s2_op_reg;
    logic [LHI_W-1:0] s2_li_reg;
    logic             s2_taken_reg;
    logic             s2_has_rec_reg;
    logic             s2_rlp_reg;
    logic             s2_rgp_reg;
    logic [GHB-1:0]   s2_rgh_reg;
    logic [LHB-1:0]   s2_lh_reg;

    // table data
    logic [LHB-1:0]             lh_rd;
    logic [LOCAL_CTR_BITS-1:0]  lc_rd;
    logic [GLOBAL_CTR_BITS-1:0] gc_rd;
    logic [CHOICE_CTR_BITS-1:0] cc_rd;
    logic [LOCAL_CTR_BITS-1:0]  lc_cur;
    logic [GLOBAL_CTR_BITS-1:0] gc_cur;
    logic [CHOICE_CTR_BITS-1:0] cc_cur;
    logic                       lp;
    logic                       gp;
    logic                       ch;
    logic                       pred;
    logic [HW-1:0]              snap_wide;

    // writes
    logic                       upd_fire;
    logic                       ch_train;
    logic [LHB-1:0]             lh_upd_data;
    logic [LOCAL_CTR_BITS-1:0]  lc_upd_data;
    logic [GLOBAL_CTR_BITS-1:0] gc_upd_data;
    logic [CHOICE_CTR_BITS-1:0] cc_upd_data;
    logic                       lh_we;
    logic                       lc_we;
    logic                       gc_we;
    logic                       cc_we;
    logic [LHI_W-1:0]           lh_waddr;
    logic [LHB-1:0]             lc_waddr;
    logic [GHB-1:0]             g_waddr;
    logic [LHB-1:0]             lh_wdata;
    logic [LOCAL_CTR_BITS-1:0]  lc_wdata;
    logic [GLOBAL_CTR_BITS-1:0] gc_wdata;
    logic [CHOICE_CTR_BITS-1:0] cc_wdata;

    // last write of each table, for reads issued at the same edge
    logic                       lhw_vld_reg;
    logic [LHI_W-1:0]           lhw_addr_reg;
    logic [LHB-1:0]             lhw_data_reg;
    logic                       lcw_vld_reg;
    logic [LHB-1:0]             lcw_addr_reg;
    logic [LOCAL_CTR_BITS-1:0]  lcw_data_reg;
    logic                       gcw_vld_reg;
    logic [GHB-1:0]             gcw_addr_reg;
    logic [GLOBAL_CTR_BITS-1:0] gcw_data_reg;
    logic                       ccw_vld_reg;
    logic [GHB-1:0]             ccw_addr_reg;
    logic [CHOICE_CTR_BITS-1:0] ccw_data_reg;

    // output register
    logic                       out_vld_reg;
    logic [OUT_W-1:0]           out_data_reg;
    logic [OUT_W-1:0]           out_data_next;

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    assign in_op        = op_t'(s_tuser);
    assign in_addr      = s_tdata[31:0];
    assign addr_shifted = in_addr >> addr_shift_reg;
    assign in_li        = addr_shifted[LHI_W-1:0] & LH_IDX_MASK;
    assign in_rgh_wide  = HW'(s_tdata[48:36]);

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv && !clr_busy_reg;
    assign in_fire  = s_tvalid && s_tready;

    assign clr_lh_ok = 32'(clr_cnt_reg) < 32'(LOCAL_HIST_ENTRIES);

    // ------------------------------------------------------------------------
    // Stage 1: local history with forwarding, history seen by this beat
    // ------------------------------------------------------------------------
    always_comb
    begin
        lh_s1 = lh_rd;
        if (lhw_vld_reg && lhw_addr_reg == s1_li_reg)
        begin
            lh_s1 = lhw_data_reg;
        end
        // the older beat in s2 writes next; it wins
        if (s2_vld_reg && s2_op_reg == OP_UPDATE && s2_li_reg == s1_li_reg)
        begin
            lh_s1 = lh_upd_data;
        end
    end

    assign gh_s1 = s2_vld_reg ? gh_next : gh_reg;

    // ------------------------------------------------------------------------
    // Stage 2: counters with forwarding, prediction and training
    // ------------------------------------------------------------------------
    assign lc_cur = (lcw_vld_reg && lcw_addr_reg == s2_lh_reg) ? lcw_data_reg : lc_rd;
    assign gc_cur = (gcw_vld_reg && gcw_addr_reg == gh_reg) ? gcw_data_reg : gc_rd;
    assign cc_cur = (ccw_vld_reg && ccw_addr_reg == gh_reg) ? ccw_data_reg : cc_rd;

    assign lp   = ctr_t'(lc_cur) > TAKEN_THR;
    assign gp   = ctr_t'(gc_cur) > TAKEN_THR;
    assign ch   = ctr_t'(cc_cur) > TAKEN_THR;
    assign pred = ch ? gp : lp;

    assign snap_wide = HW'(gh_reg);

    assign ch_train    = s2_has_rec_reg && (s2_rlp_reg != s2_rgp_reg);
    assign lh_upd_data = LHB'({s2_lh_reg, s2_taken_reg});
    assign lc_upd_data = LOCAL_CTR_BITS'(ctr_train(ctr_t'(lc_cur), s2_taken_reg, LC_MAX));
    assign gc_upd_data = GLOBAL_CTR_BITS'(ctr_train(ctr_t'(gc_cur), s2_taken_reg, GC_MAX));
    // up when the global side was right, down when the local side was
    assign cc_upd_data = CHOICE_CTR_BITS'(ctr_train(ctr_t'(cc_cur),
                                                    s2_rlp_reg != s2_taken_reg, CC_MAX));

    always_comb
    begin
        gh_next       = gh_reg;
        out_data_next = '0;
        case (s2_op_reg)
            OP_LOOKUP:
            begin
                out_data_next = {snap_wide[SNAP_W-1:0], ch, gp, lp, pred};
                gh_next       = GHB'({gh_reg, pred});
            end
            OP_UNCOND:
            begin
                out_data_next = {snap_wide[SNAP_W-1:0], 1'b0, 1'b1, 1'b1, 1'b1};
                gh_next       = GHB'({gh_reg, 1'b1});
            end
            OP_UPDATE:
            begin
                gh_next = gh_reg;
            end
            OP_SQUASH:
            begin
                gh_next = s2_rgh_reg;
            end
            default:
            begin
                gh_next = gh_reg;
            end
        endcase
    end

    assign upd_fire = adv && s2_vld_reg && s2_op_reg == OP_UPDATE;

    // ------------------------------------------------------------------------
    // Table write ports: clearing pass, then training
    // ------------------------------------------------------------------------
    assign lh_we    = clr_busy_reg ? clr_lh_ok : upd_fire;
    assign lc_we    = clr_busy_reg || upd_fire;
    assign gc_we    = clr_busy_reg || upd_fire;
    assign cc_we    = clr_busy_reg || (upd_fire && ch_train);
    assign lh_waddr = clr_busy_reg ? clr_cnt_reg[LHI_W-1:0] : s2_li_reg;
    assign lc_waddr = clr_busy_reg ? clr_cnt_reg[LHB-1:0] : s2_lh_reg;
    assign g_waddr  = clr_busy_reg ? clr_cnt_reg[GHB-1:0] : gh_reg;
    assign lh_wdata = clr_busy_reg ? '0 : lh_upd_data;
    assign lc_wdata = clr_busy_reg ? '0 : lc_upd_data;
    assign gc_wdata = clr_busy_reg ? '0 : gc_upd_data;
    assign cc_wdata = clr_busy_reg ? '0 : cc_upd_data;

    tbp_ram #(
        .W     (LHB),
        .DEPTH (LOCAL_HIST_ENTRIES),
        .AW    (LHI_W)
    ) u_lh_ram (
        .clk   (clk),
        .we    (lh_we),
        .waddr (lh_waddr),
        .wdata (lh_wdata),
        .re    (adv),
        .raddr (in_li),
        .rdata (lh_rd)
    );

    tbp_ram #(
        .W     (LOCAL_CTR_BITS),
        .DEPTH (LC_DEPTH),
        .AW    (LHB)
    ) u_lc_ram (
        .clk   (clk),
        .we    (lc_we),
        .waddr (lc_waddr),
        .wdata (lc_wdata),
        .re    (adv),
        .raddr (lh_s1),
        .rdata (lc_rd)
    );

    tbp_ram #(
        .W     (GLOBAL_CTR_BITS),
        .DEPTH (GC_DEPTH),
        .AW    (GHB)
    ) u_gc_ram (
        .clk   (clk),
        .we    (gc_we),
        .waddr (g_waddr),
        .wdata (gc_wdata),
        .re    (adv),
        .raddr (gh_s1),
        .rdata (gc_rd)
    );

    tbp_ram #(
        .W     (CHOICE_CTR_BITS),
        .DEPTH (GC_DEPTH),
        .AW    (GHB)
    ) u_cc_ram (
        .clk   (clk),
        .we    (cc_we),
        .waddr (g_waddr),
        .wdata (cc_wdata),
        .re    (adv),
        .raddr (gh_s1),
        .rdata (cc_rd)
    );

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
            addr_shift_reg <= ADDR_SHIFT_RST;
            gh_reg         <= '0;
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            lhw_vld_reg    <= 1'b0;
            lcw_vld_reg    <= 1'b0;
            gcw_vld_reg    <= 1'b0;
            ccw_vld_reg    <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
                if (&clr_cnt_reg)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cfg_wr_en)
            begin
                addr_shift_reg <= cfg_wr_data;
            end
            if (adv)
            begin
                s1_vld_reg  <= in_fire;
                s2_vld_reg  <= s1_vld_reg;
                out_vld_reg <= s2_vld_reg;
                lhw_vld_reg <= upd_fire;
                lcw_vld_reg <= upd_fire;
                gcw_vld_reg <= upd_fire;
                ccw_vld_reg <= upd_fire && ch_train;
                if (s2_vld_reg)
                begin
                    gh_reg <= gh_next;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline payload: advance together, hold on output stall
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg      <= in_op;
            s1_li_reg      <= in_li;
            s1_taken_reg   <= s_tdata[32];
            s1_has_rec_reg <= s_tdata[33];
            s1_rlp_reg     <= s_tdata[34];
            s1_rgp_reg     <= s_tdata[35];
            s1_rgh_reg     <= in_rgh_wide[GHB-1:0];

            s2_op_reg      <= s1_op_reg;
            s2_li_reg      <= s1_li_reg;
            s2_taken_reg   <= s1_taken_reg;
            s2_has_rec_reg <= s1_has_rec_reg;
            s2_rlp_reg     <= s1_rlp_reg;
            s2_rgp_reg     <= s1_rgp_reg;
            s2_rgh_reg     <= s1_rgh_reg;
            s2_lh_reg      <= lh_s1;

            lhw_addr_reg   <= s2_li_reg;
            lhw_data_reg   <= lh_upd_data;
            lcw_addr_reg   <= s2_lh_reg;
            lcw_data_reg   <= lc_upd_data;
            gcw_addr_reg   <= gh_reg;
            gcw_data_reg   <= gc_upd_data;
            ccw_addr_reg   <= gh_reg;
            ccw_data_reg   <= cc_upd_data;

            out_data_reg   <= out_data_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(24 - OUT_W){1'b0}}, out_data_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_gh_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(gh_reg))
        else $error("global history moved during an output stall");

    a_clear_wraps : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_busy_reg) |-> clr_cnt_reg == '0)
        else $error("clearing pass ended before sweeping every entry");

    a_no_beat_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |=> !s1_vld_reg)
        else $error("beat entered the pipeline during the clearing pass");

    a_update_zero_result : assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s2_vld_reg && s2_op_reg == OP_UPDATE) |=> (m_tvalid && m_tdata == '0))
        else $error("update beat produced a nonzero result");

    a_no_train_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (lc_we || cc_we) |-> (adv || clr_busy_reg))
        else $error("table written while the pipeline was stalled");

endmodule : tournament_branch_predictor
`default_nettype wire
